// ===== rtl/core/i2cmbe_pkg.sv =====
package i2cmbe_pkg;

	localparam int TICK_CNT_W = 16;
	localparam logic [15:0] PHASE_TICKS_RST = 16'd165;

	localparam logic [4:0] STEP_IDLE = 5'd0;
	localparam logic [4:0] STEP_FIRST = 5'd1;
	localparam logic [4:0] LAST_STEP_SHORT = 5'd2;
	localparam logic [4:0] LAST_STEP_WRITE = 5'd27;
	localparam logic [4:0] LAST_STEP_READ = 5'd19;
	localparam logic [4:0] WR_BITS_END = 5'd24;
	localparam logic [4:0] WR_ACK_SAMPLE = 5'd26;
	localparam logic [4:0] RD_BITS_END = 5'd16;
	localparam logic [4:0] RD_ACK_HIGH = 5'd18;
	localparam logic [4:0] RD_RELEASE = 5'd19;

	localparam logic [1:0] K_LOW_HOLD = 2'd0;
	localparam logic [1:0] K_LOW_DATA = 2'd1;
	localparam logic [1:0] K_HIGH = 2'd2;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_STOP  = 2'd1,
		MODE_WRITE = 2'd2,
		MODE_READ  = 2'd3
	} mode_t;

	typedef struct packed {
		logic       start_cmd;
		mode_t      mode;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       sda_in;
	} req_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_received;
	} rsp_t;

	// Queue entry: the request's fields, with start_cmd stored as is_cmd.
	typedef struct packed {
		logic       is_cmd;
		mode_t      mode;
		logic [7:0] tx_byte;
		logic       ack_to_send;
		logic       sda_in;
	} entry_t;

	typedef struct packed {
		logic scl;
		logic sda;
	} lines_t;

	function automatic logic [4:0] last_phase(mode_t m);
		logic [4:0] r;
		unique case (m)
			MODE_WRITE: r = LAST_STEP_WRITE;
			MODE_READ:  r = LAST_STEP_READ;
			default:    r = LAST_STEP_SHORT;
		endcase
		return r;
	endfunction

	// Position of a write phase within its bit, (p - 1) mod 3, for p from 1 to 24.
	function automatic logic [1:0] bit_phase(logic [4:0] p);
		logic [4:0] x;
		logic [8:0] prod;
		logic [2:0] q;
		logic [4:0] rem;
		x = p - 5'd1;
		prod = 9'(x) * 9'd11;
		q = prod[7:5];
		rem = x - 5'(q) * 5'd3;
		return rem[1:0];
	endfunction

	function automatic lines_t drive_phase(mode_t m, logic [4:0] p, logic msb, logic ackp,
			lines_t cur);
		lines_t r;
		r = cur;
		unique case (m)
			MODE_START: begin
				r.scl = 1'b1;
				r.sda = (p == STEP_FIRST);
			end
			MODE_STOP: begin
				r.scl = 1'b1;
				r.sda = (p != STEP_FIRST);
			end
			MODE_WRITE: begin
				if (p <= WR_BITS_END) begin
					unique case (bit_phase(p))
						K_LOW_HOLD: r.scl = 1'b0;
						K_LOW_DATA: begin
							r.scl = 1'b0;
							r.sda = msb;
						end
						default: r.scl = 1'b1;
					endcase
				end else begin
					r.scl = (p == WR_ACK_SAMPLE);
					r.sda = 1'b1;
				end
			end
			default: begin
				if (p <= RD_BITS_END) begin
					r.scl = p[0];
					r.sda = 1'b1;
				end else if (p == RD_RELEASE) begin
					r.scl = 1'b0;
					r.sda = 1'b1;
				end else begin
					r.scl = (p == RD_ACK_HIGH);
					r.sda = ackp;
				end
			end
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/i2cmbe_front.sv =====
module i2cmbe_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  i2cmbe_pkg::req_t     req,
	output logic                 q_valid,
	input  logic                 q_pop,
	output i2cmbe_pkg::entry_t   q_head
);
	import i2cmbe_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	entry_t     ent;

	assign req_ready = (count_q != 2'd2);
	assign push = req_valid && req_ready;
	assign q_valid = (count_q != 2'd0);
	assign q_head = mem_q[rd_ptr_q];

	always_comb begin
		ent.is_cmd = req.start_cmd;
		ent.mode = req.mode;
		ent.tx_byte = req.tx_byte;
		ent.ack_to_send = req.ack_to_send;
		ent.sda_in = req.sda_in;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// ===== rtl/core/i2cmbe_back.sv =====
module i2cmbe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [15:0]          phase_ticks,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  i2cmbe_pkg::entry_t   q_head,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output i2cmbe_pkg::rsp_t     rsp
);
	import i2cmbe_pkg::*;

	localparam int CMP_W = ((TICK_CNT_W > 16) ? TICK_CNT_W : 16) + 1;

	logic [TICK_CNT_W-1:0] tick_q, tick_n;
	logic [4:0]            step_q, step_n;
	mode_t                 mode_q, mode_n;
	logic [7:0]            shift_q, shift_n;
	logic [7:0]            recv_q, recv_n;
	logic                  ack_seen_q, ack_seen_n;
	logic                  ackp_q, ackp_n;
	lines_t                lines_q, lines_n;
	logic                  done;
	logic                  phase_end;
	logic                  out_valid_q;
	rsp_t                  rsp_q;
	logic                  fire;

	assign fire = q_valid && (!out_valid_q || rsp_ready);
	assign q_pop = fire;
	assign rsp_valid = out_valid_q;
	assign rsp = rsp_q;

	assign phase_end = ((CMP_W'(tick_q) + CMP_W'(1)) >= CMP_W'(phase_ticks))
		|| (tick_q == {TICK_CNT_W{1'b1}});

	always_comb begin
		tick_n = tick_q;
		step_n = step_q;
		mode_n = mode_q;
		shift_n = shift_q;
		recv_n = recv_q;
		ack_seen_n = ack_seen_q;
		ackp_n = ackp_q;
		lines_n = lines_q;
		done = 1'b0;
		if (step_q == STEP_IDLE) begin
			if (q_head.is_cmd) begin
				mode_n = q_head.mode;
				shift_n = q_head.tx_byte;
				ackp_n = q_head.ack_to_send;
				tick_n = '0;
				step_n = STEP_FIRST;
				lines_n = drive_phase(q_head.mode, STEP_FIRST, q_head.tx_byte[7],
					q_head.ack_to_send, lines_q);
			end
		end else if (phase_end) begin
			if (mode_q == MODE_WRITE) begin
				if (step_q <= WR_BITS_END && bit_phase(step_q) == K_HIGH) begin
					shift_n = {shift_q[6:0], 1'b0};
				end else if (step_q == WR_ACK_SAMPLE) begin
					ack_seen_n = q_head.sda_in;
				end
			end else if (mode_q == MODE_READ) begin
				if (step_q <= RD_BITS_END && step_q[0]) begin
					shift_n = {shift_q[6:0], q_head.sda_in};
				end
				if (step_q == RD_BITS_END) begin
					recv_n = shift_q;
				end
			end
			tick_n = '0;
			if (step_q >= last_phase(mode_q)) begin
				step_n = STEP_IDLE;
				done = 1'b1;
				if (mode_q == MODE_START) begin
					lines_n.scl = 1'b0;
				end
			end else begin
				step_n = step_q + 5'd1;
				lines_n = drive_phase(mode_q, step_n, shift_n[7], ackp_q, lines_q);
			end
		end else begin
			tick_n = tick_q + TICK_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			step_q <= STEP_IDLE;
			mode_q <= MODE_START;
			shift_q <= 8'd0;
			recv_q <= 8'd0;
			ack_seen_q <= 1'b1;
			ackp_q <= 1'b0;
			lines_q <= '{scl: 1'b1, sda: 1'b1};
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				tick_q <= tick_n;
				step_q <= step_n;
				mode_q <= mode_n;
				shift_q <= shift_n;
				recv_q <= recv_n;
				ack_seen_q <= ack_seen_n;
				ackp_q <= ackp_n;
				lines_q <= lines_n;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q.scl_out <= lines_n.scl;
			rsp_q.sda_out <= lines_n.sda;
			rsp_q.busy_res <= (step_n != STEP_IDLE);
			rsp_q.done_res <= done;
			rsp_q.rx_byte <= recv_n;
			rsp_q.ack_received <= ack_seen_n;
		end
	end

endmodule

// ===== rtl/core/i2c_master_bit_engine_core.sv =====
// Channel    Direction  Handshake            Payload
// req        in         req_valid/req_ready  req_t: start_cmd, mode, tx_byte, ack_to_send, sda_in
// rsp        out        rsp_valid/rsp_ready  rsp_t: scl_out, sda_out, busy, done, rx_byte, ack
// cfg        in         cfg_we               cfg_wdata: phase_ticks
//
// One item per cycle sustained while rsp is not stalled; an item is first written into
// the two-entry queue, and its result is then held in the output register.
// Reset empties the queue and clears the output valid and the sequencer state; phase_ticks
// returns to 165.
// A stalled rsp holds the sequencer; req keeps being taken until the queue is full.
module i2c_master_bit_engine_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  i2cmbe_pkg::req_t   req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output i2cmbe_pkg::rsp_t   rsp,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata
);
	import i2cmbe_pkg::*;

	logic [15:0] phase_ticks_q;
	logic        q_valid;
	logic        q_pop;
	entry_t      q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	i2cmbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_head    (q_head)
	);

	i2cmbe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_ticks (phase_ticks_q),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_head      (q_head),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

endmodule

// ===== rtl/core/i2cmbe_checker.sv =====
module i2cmbe_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_ready,
	input  logic               rsp_valid,
	input  logic               rsp_ready,
	input  i2cmbe_pkg::rsp_t   rsp
);

	// A held result keeps its value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp changed while stalled");

	// The queue only fills up behind a stalled result.
	a_full_needs_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid)
		else $error("req stalled with no result pending");

	// A finishing command leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.done_res |-> !rsp.busy_res)
		else $error("done with busy set");

	// Two results in a row never both report done.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp.done_res |=> !(rsp_valid && rsp.done_res))
		else $error("done lasted more than one item");

endmodule

bind i2c_master_bit_engine_core i2cmbe_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
